/* hw/rtl/dpd_pkg.sv */
`default_nettype none
// dpd_pkg: types, codes and helpers shared by the debug packet deframer.
// No dependencies; imported by dpd_front, dpd_back and the top level.

package dpd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 9;
    localparam int IDX_W  = 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [IDX_W-1:0] CFG_END   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_ACK   = 2'd2;
    localparam logic [IDX_W-1:0] CFG_NAK   = 2'd3;

    localparam logic [BYTE_W-1:0] START_RST = 8'd36;
    localparam logic [BYTE_W-1:0] END_RST   = 8'd35;
    localparam logic [BYTE_W-1:0] ACK_RST   = 8'd43;
    localparam logic [BYTE_W-1:0] NAK_RST   = 8'd45;

    localparam logic [BYTE_W-1:0] CH_0 = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9 = 8'h39;
    localparam logic [BYTE_W-1:0] CH_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_F = 8'h66;
    localparam logic [BYTE_W-1:0] HEX_A_VAL = 8'd10;

    typedef enum logic [1:0] {
        RX_BYTE    = 2'd0,
        RX_BAD     = 2'd1,
        RX_TIMEOUT = 2'd2,
        RX_UNUSED  = 2'd3
    } t_rx_kind;

    typedef enum logic [1:0] {
        RES_BYTE     = 2'd0,
        RES_GOOD     = 2'd1,
        RES_REJECT   = 2'd2,
        RES_OVERFLOW = 2'd3
    } t_res_kind;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_DATA = 2'd1,
        PH_HIGH = 2'd2,
        PH_LOW  = 2'd3
    } t_phase;

    // Classified serial event handed from front to back
    typedef struct packed {
        t_rx_kind          kind;
        logic [BYTE_W-1:0] data;
        logic              is_start;
        logic              is_end;
        logic              hex_ok;
        logic [3:0]        hex_val;
    } t_event;

    // One result transaction
    typedef struct packed {
        t_res_kind         kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  byte_index;
        logic [LEN_W-1:0]  packet_length;
        logic [BYTE_W-1:0] reply_char;
    } t_result;

    // Lower-case hex digit decode: {valid, value}
    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] d;
        d = '0;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
            return {1'b1, d[3:0]};
        end else if (c >= CH_A && c <= CH_F) begin
            d = c - CH_A + HEX_A_VAL;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/dpd_fifo.sv */
`default_nettype none
// dpd_fifo: small register-based first-in first-out queue.
// Generic; no package dependency. Used between front and back and at the output.

module dpd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_wr, w_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT) else $error("fifo count beyond depth");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |=> $stable(r_wptr)) else $error("write while full");
    a_empty_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && !i_push) |=> o_empty) else $error("fifo filled without push");
`endif

endmodule

`default_nettype wire

/* hw/rtl/dpd_front.sv */
`default_nettype none
// dpd_front: accepts serial events, classifies them and queues them for the back end.
// Depends on dpd_pkg and dpd_fifo.

module dpd_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire dpd_pkg::t_rx_kind             i_rx_kind,
    input  wire logic [dpd_pkg::BYTE_W-1:0]    i_rx_byte,
    input  wire logic [dpd_pkg::BYTE_W-1:0]    i_start_char,
    input  wire logic [dpd_pkg::BYTE_W-1:0]    i_end_char,
    output dpd_pkg::t_event                    o_event,
    output logic                               o_event_valid,
    input  wire logic                          i_event_take
);
    import dpd_pkg::*;

    t_event     w_event;
    logic [4:0] w_hex;
    logic       w_is_byte;
    logic       w_enq;
    logic       w_empty;
    logic [$bits(t_event)-1:0] w_q_out;

    // Classify the incoming event
    always_comb begin
        w_is_byte        = (i_rx_kind == RX_BYTE);
        w_hex            = hex_decode(i_rx_byte);
        w_event.kind     = i_rx_kind;
        w_event.data     = i_rx_byte;
        w_event.is_start = w_is_byte && (i_rx_byte == i_start_char);
        w_event.is_end   = w_is_byte && (i_rx_byte == i_end_char);
        w_event.hex_ok   = w_is_byte && w_hex[4];
        w_event.hex_val  = w_hex[3:0];
    end

    // The unused kind has no effect, so it is dropped here
    assign w_enq = push && (i_rx_kind != RX_UNUSED);

    dpd_fifo #(
        .WIDTH ($bits(t_event)),
        .DEPTH (2)
    ) u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_enq),
        .i_data  (w_event),
        .o_full  (full),
        .i_pop   (i_event_take),
        .o_data  (w_q_out),
        .o_empty (w_empty)
    );

    assign o_event       = t_event'(w_q_out);
    assign o_event_valid = !w_empty;

`ifndef SYNTHESIS
    a_start_is_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event_valid && o_event.is_start) |-> (o_event.kind == RX_BYTE))
        else $error("start flag on non-byte event");
    a_hex_is_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event_valid && o_event.hex_ok) |-> (o_event.kind == RX_BYTE))
        else $error("hex flag on non-byte event");
    a_no_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event_valid |-> (o_event.kind != RX_UNUSED))
        else $error("unused event kind queued");
`endif

endmodule

`default_nettype wire

/* hw/rtl/dpd_back.sv */
`default_nettype none
// dpd_back: packet state machine; tracks phase, sum and count and builds results.
// Depends on dpd_pkg.

module dpd_back #(
    parameter int BUFFER_BYTES = 512
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dpd_pkg::t_event               i_event,
    input  wire logic                          i_event_valid,
    output logic                               o_event_take,
    input  wire logic [dpd_pkg::BYTE_W-1:0]    i_ack_char,
    input  wire logic [dpd_pkg::BYTE_W-1:0]    i_nak_char,
    output dpd_pkg::t_result                   o_result,
    output logic                               o_result_push,
    input  wire logic                          i_result_full
);
    import dpd_pkg::*;

    localparam int CW = $clog2(BUFFER_BYTES);
    localparam logic [CW-1:0] LAST = CW'(BUFFER_BYTES - 1);

    t_phase            r_phase, n_phase;
    logic              r_seen_any, n_seen_any;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic              r_bad, n_bad;
    logic [CW-1:0]     r_count, n_count;
    logic [3:0]        r_high, n_high;
    logic              r_dig_inv, n_dig_inv;

    logic              w_fire;
    logic [CW+LEN_W-1:0] w_count_ext;
    logic [LEN_W-1:0]  w_count9;
    logic              w_good;

    assign w_fire       = i_event_valid && !i_result_full;
    assign o_event_take = w_fire;
    assign w_count_ext  = {{LEN_W{1'b0}}, r_count};
    assign w_count9     = w_count_ext[LEN_W-1:0];
    assign w_good       = !r_bad && !r_dig_inv && i_event.hex_ok
                          && (r_sum == {r_high, i_event.hex_val});

    // Next state
    always_comb begin
        n_phase    = r_phase;
        n_seen_any = r_seen_any;
        n_sum      = r_sum;
        n_bad      = r_bad;
        n_count    = r_count;
        n_high     = r_high;
        n_dig_inv  = r_dig_inv;
        if (w_fire) begin
            if (r_phase == PH_HUNT) begin
                if (i_event.kind == RX_TIMEOUT) begin
                    n_seen_any = 1'b0;
                end else begin
                    n_seen_any = 1'b1;
                    if (i_event.is_start) begin
                        n_phase   = PH_DATA;
                        n_sum     = '0;
                        n_count   = '0;
                        n_bad     = 1'b0;
                        n_dig_inv = 1'b0;
                        n_high    = '0;
                    end
                end
            end else if (i_event.kind == RX_TIMEOUT) begin
                n_phase    = PH_HUNT;
                n_seen_any = 1'b0;
            end else begin
                case (r_phase)
                    PH_DATA: begin
                        if (i_event.kind == RX_BAD) begin
                            n_bad = 1'b1;
                        end else if (i_event.is_start) begin
                            n_sum     = '0;
                            n_count   = '0;
                            n_bad     = 1'b0;
                            n_dig_inv = 1'b0;
                            n_high    = '0;
                        end else if (i_event.is_end) begin
                            n_phase   = PH_HIGH;
                            n_dig_inv = 1'b0;
                            n_high    = '0;
                        end else if (r_count >= LAST) begin
                            n_phase    = PH_HUNT;
                            n_seen_any = 1'b0;
                        end else begin
                            n_count = r_count + 1'b1;
                            n_sum   = r_sum + i_event.data;
                        end
                    end
                    PH_HIGH: begin
                        n_phase = PH_LOW;
                        if (i_event.hex_ok) begin
                            n_high = i_event.hex_val;
                        end else begin
                            n_dig_inv = 1'b1;
                            n_high    = '0;
                        end
                    end
                    default: begin
                        n_phase    = PH_HUNT;
                        n_seen_any = 1'b0;
                    end
                endcase
            end
        end
    end

    // Result transaction
    always_comb begin
        o_result      = '0;
        o_result_push = 1'b0;
        if (w_fire) begin
            if (i_event.kind == RX_TIMEOUT) begin
                if (r_phase != PH_HUNT || r_seen_any) begin
                    o_result_push       = 1'b1;
                    o_result.kind       = RES_REJECT;
                    o_result.reply_char = i_nak_char;
                end
            end else begin
                case (r_phase)
                    PH_DATA: begin
                        if (i_event.kind == RX_BYTE && !i_event.is_start
                                && !i_event.is_end) begin
                            o_result_push = 1'b1;
                            if (r_count >= LAST) begin
                                o_result.kind          = RES_OVERFLOW;
                                o_result.packet_length = w_count9;
                            end else begin
                                o_result.kind         = RES_BYTE;
                                o_result.payload_byte = i_event.data;
                                o_result.byte_index   = w_count9;
                            end
                        end
                    end
                    PH_LOW: begin
                        o_result_push          = 1'b1;
                        o_result.packet_length = w_count9;
                        if (w_good) begin
                            o_result.kind       = RES_GOOD;
                            o_result.reply_char = i_ack_char;
                        end else begin
                            o_result.kind       = RES_REJECT;
                            o_result.reply_char = i_nak_char;
                        end
                    end
                    default: begin
                        o_result_push = 1'b0;
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_seen_any <= 1'b0;
            r_sum      <= '0;
            r_bad      <= 1'b0;
            r_count    <= '0;
            r_high     <= '0;
            r_dig_inv  <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_seen_any <= n_seen_any;
            r_sum      <= n_sum;
            r_bad      <= n_bad;
            r_count    <= n_count;
            r_high     <= n_high;
            r_dig_inv  <= n_dig_inv;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST) else $error("payload count past buffer");
    a_first_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_phase == PH_HUNT && i_event.kind == RX_TIMEOUT && !r_seen_any)
        |-> !o_result_push) else $error("result on first hunting timeout");
    a_end_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_push && o_result.kind != RES_BYTE) |=>
        (r_phase == PH_HUNT && !r_seen_any)) else $error("no hunt after packet end");
    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_push |-> !i_result_full) else $error("result pushed into full queue");
`endif

endmodule

`default_nettype wire

/* hw/rtl/debug_packet_deframer_checksum.sv */
`default_nettype none
// debug_packet_deframer_checksum: top level of the serial debug packet receiver.
// Depends on dpd_pkg, dpd_fifo, dpd_front and dpd_back.
//
//  channel   direction  handshake               payload
//  events    in         push / full             i_rx_kind, i_rx_byte
//  results   out        pop / empty             o_result_kind .. o_reply_char
//  config    in         i_cfg_we (no wait)      i_cfg_idx, i_cfg_data
//
// One event per cycle sustained while neither queue is full; a result passes through
// the event queue, then the result queue, before it leaves.
// Throughput is set by the packet state update in dpd_back.
// Reset is synchronous, active low; no clearing pass is needed.
// Each side stalls on its own behind a two-entry queue.

module debug_packet_deframer_checksum #(
    parameter int BUFFER_BYTES = 512
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // event channel
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [1:0]                    i_rx_kind,
    input  wire logic [dpd_pkg::BYTE_W-1:0]    i_rx_byte,
    // result channel
    output logic                               empty,
    input  wire logic                          pop,
    output logic [1:0]                         o_result_kind,
    output logic [dpd_pkg::BYTE_W-1:0]         o_payload_byte,
    output logic [dpd_pkg::LEN_W-1:0]          o_byte_index,
    output logic [dpd_pkg::LEN_W-1:0]          o_packet_length,
    output logic [dpd_pkg::BYTE_W-1:0]         o_reply_char,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [dpd_pkg::IDX_W-1:0]     i_cfg_idx,
    input  wire logic [dpd_pkg::BYTE_W-1:0]    i_cfg_data
);
    import dpd_pkg::*;

    logic [BYTE_W-1:0] r_start_char, r_end_char, r_ack_char, r_nak_char;

    t_event  w_event;
    logic    w_event_valid, w_event_take;
    t_result w_result, w_out;
    logic    w_result_push, w_result_full;
    logic [$bits(t_result)-1:0] w_out_raw;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char <= START_RST;
            r_end_char   <= END_RST;
            r_ack_char   <= ACK_RST;
            r_nak_char   <= NAK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START: r_start_char <= i_cfg_data;
                CFG_END:   r_end_char   <= i_cfg_data;
                CFG_ACK:   r_ack_char   <= i_cfg_data;
                CFG_NAK:   r_nak_char   <= i_cfg_data;
                default:   r_start_char <= r_start_char;
            endcase
        end
    end

    // Front: accept and classify
    dpd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_rx_kind     (t_rx_kind'(i_rx_kind)),
        .i_rx_byte     (i_rx_byte),
        .i_start_char  (r_start_char),
        .i_end_char    (r_end_char),
        .o_event       (w_event),
        .o_event_valid (w_event_valid),
        .i_event_take  (w_event_take)
    );

    // Back: packet state machine
    dpd_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_event       (w_event),
        .i_event_valid (w_event_valid),
        .o_event_take  (w_event_take),
        .i_ack_char    (r_ack_char),
        .i_nak_char    (r_nak_char),
        .o_result      (w_result),
        .o_result_push (w_result_push),
        .i_result_full (w_result_full)
    );

    // Result queue
    dpd_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_result_push),
        .i_data  (w_result),
        .o_full  (w_result_full),
        .i_pop   (pop),
        .o_data  (w_out_raw),
        .o_empty (empty)
    );

    assign w_out           = t_result'(w_out_raw);
    assign o_result_kind   = w_out.kind;
    assign o_payload_byte  = w_out.payload_byte;
    assign o_byte_index    = w_out.byte_index;
    assign o_packet_length = w_out.packet_length;
    assign o_reply_char    = w_out.reply_char;

`ifndef SYNTHESIS
    a_byte_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_kind == RES_BYTE) |-> (o_packet_length == '0
        && o_reply_char == '0)) else $error("payload result carries end fields");
    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_kind != RES_BYTE) |-> (o_payload_byte == '0
        && o_byte_index == '0)) else $error("end result carries byte fields");
    a_overflow_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_kind == RES_OVERFLOW) |-> (o_reply_char == '0))
        else $error("overflow result with reply byte");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// tb: self-checking bench for debug_packet_deframer_checksum.
// Depends on dpd_pkg and the deframer RTL; streams serial events, predicts each
// result transaction in a local deframer model and checks it field by field.

module tb;
    import dpd_pkg::*;

    localparam int BUFFER_BYTES = 512;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE       = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 150;

    typedef struct packed {
        t_rx_kind          kind;
        logic [BYTE_W-1:0] data;
    } t_rx_item;

    // DUT ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [1:0]         i_rx_kind = RX_UNUSED;
    logic [BYTE_W-1:0]  i_rx_byte = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [1:0]         o_result_kind;
    logic [BYTE_W-1:0]  o_payload_byte;
    logic [LEN_W-1:0]   o_byte_index;
    logic [LEN_W-1:0]   o_packet_length;
    logic [BYTE_W-1:0]  o_reply_char;
    logic               i_cfg_we = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx = CFG_START;
    logic [BYTE_W-1:0]  i_cfg_data = '0;

    // Stimulus and scoreboard storage
    t_rx_item rx_events[$];
    t_result  deframer_out_q[$];
    int       n_gen = 0;
    int       n_results = 0;
    int       n_errors = 0;
    int       cyc = 0;
    int       holdoff = 0;
    bit       held_once = 1'b0;
    logic     no_idle;
    t_result  got;
    t_result  want;

    // Local copy of configuration and deframer state
    logic [BYTE_W-1:0] cfg_start = START_RST;
    logic [BYTE_W-1:0] cfg_end   = END_RST;
    logic [BYTE_W-1:0] cfg_ack   = ACK_RST;
    logic [BYTE_W-1:0] cfg_nak   = NAK_RST;
    t_phase            ph        = PH_HUNT;
    logic              seen_any  = 1'b0;
    logic [BYTE_W-1:0] sum       = '0;
    logic              bad_seen  = 1'b0;
    logic [LEN_W-1:0]  byte_cnt  = '0;
    logic [3:0]        high_nib  = '0;
    logic              digit_bad = 1'b0;

    debug_packet_deframer_checksum #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_rx_kind      (i_rx_kind),
        .i_rx_byte      (i_rx_byte),
        .empty          (empty),
        .pop            (pop),
        .o_result_kind  (o_result_kind),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_packet_length(o_packet_length),
        .o_reply_char   (o_reply_char),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // No random idling on either side inside this window
    assign no_idle = (cyc >= 800) && (cyc < 1400);

    // ------------------------------------------------------------------
    // Deframer prediction
    // ------------------------------------------------------------------

    // Lower-case hex digit value, bit 4 set when the byte is not a digit
    function automatic logic [4:0] hex_nibble(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] d;
        d = c - CH_A + HEX_A_VAL;
        if (c >= CH_0 && c <= CH_9)
            return {1'b0, c[3:0]};
        if (c >= CH_A && c <= CH_F)
            return {1'b0, d[3:0]};
        return 5'h10;
    endfunction

    function automatic t_result mk_result(input t_res_kind k, input logic [BYTE_W-1:0] b,
                                          input logic [LEN_W-1:0] idx,
                                          input logic [LEN_W-1:0] len,
                                          input logic [BYTE_W-1:0] reply);
        t_result r;
        r.kind          = k;
        r.payload_byte  = b;
        r.byte_index    = idx;
        r.packet_length = len;
        r.reply_char    = reply;
        return r;
    endfunction

    task automatic go_hunt();
        ph       = PH_HUNT;
        seen_any = 1'b0;
    endtask

    task automatic open_packet();
        ph        = PH_DATA;
        sum       = '0;
        byte_cnt  = '0;
        bad_seen  = 1'b0;
        digit_bad = 1'b0;
        high_nib  = '0;
    endtask

    // Advance the model by one accepted serial event
    task automatic deframe_event(input t_rx_kind k, input logic [BYTE_W-1:0] c);
        logic [4:0] v;
        logic       good;
        v = (k == RX_BYTE) ? hex_nibble(c) : 5'h10;
        if (k == RX_UNUSED)
            return;
        if (ph == PH_HUNT) begin
            if (k == RX_TIMEOUT) begin
                // a timeout with nothing seen in this hunt is dropped
                if (seen_any) begin
                    go_hunt();
                    deframer_out_q.push_back(mk_result(RES_REJECT, '0, '0, '0, cfg_nak));
                end
                return;
            end
            seen_any = 1'b1;
            if (k == RX_BYTE && c == cfg_start)
                open_packet();
            return;
        end
        if (k == RX_TIMEOUT) begin
            go_hunt();
            deframer_out_q.push_back(mk_result(RES_REJECT, '0, '0, '0, cfg_nak));
            return;
        end
        case (ph)
            PH_DATA: begin
                if (k == RX_BAD) begin
                    bad_seen = 1'b1;
                end else if (c == cfg_start) begin
                    open_packet();
                end else if (c == cfg_end) begin
                    ph        = PH_HIGH;
                    digit_bad = 1'b0;
                    high_nib  = '0;
                end else if (byte_cnt >= LEN_W'(BUFFER_BYTES - 1)) begin
                    deframer_out_q.push_back(mk_result(RES_OVERFLOW, '0, '0, byte_cnt, '0));
                    go_hunt();
                end else begin
                    deframer_out_q.push_back(mk_result(RES_BYTE, c, byte_cnt, '0, '0));
                    byte_cnt = byte_cnt + 1'b1;
                    sum      = sum + c;
                end
            end
            PH_HIGH: begin
                if (v[4]) begin
                    digit_bad = 1'b1;
                    high_nib  = '0;
                end else begin
                    high_nib = v[3:0];
                end
                ph = PH_LOW;
            end
            default: begin
                good = !bad_seen && !digit_bad && !v[4] && (sum == {high_nib, v[3:0]});
                if (good)
                    deframer_out_q.push_back(mk_result(RES_GOOD, '0, '0, byte_cnt, cfg_ack));
                else
                    deframer_out_q.push_back(mk_result(RES_REJECT, '0, '0, byte_cnt, cfg_nak));
                go_hunt();
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Event driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full)
                deframe_event(t_rx_kind'(i_rx_kind), i_rx_byte);
            if (!push || !full) begin
                if (rx_events.size() != 0 && (no_idle || $urandom_range(99) >= 9)) begin
                    push      <= 1'b1;
                    i_rx_kind <= rx_events[0].kind;
                    i_rx_byte <= rx_events[0].data;
                    rx_events.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got = mk_result(t_res_kind'(o_result_kind), o_payload_byte, o_byte_index,
                                o_packet_length, o_reply_char);
                n_results++;
                if (deframer_out_q.size() == 0) begin
                    $display("%0t: unexpected result transaction kind %0d byte %0d",
                             $time, got.kind, got.payload_byte);
                    $display("%0t:   idx %0d len %0d reply %0d",
                             $time, got.byte_index, got.packet_length, got.reply_char);
                    n_errors++;
                end else begin
                    want = deframer_out_q.pop_front();
                    if (got.kind != want.kind) begin
                        $display("%0t: result_kind expected %0d actual %0d",
                                 $time, want.kind, got.kind);
                        n_errors++;
                    end
                    if (got.payload_byte != want.payload_byte) begin
                        $display("%0t: payload_byte expected %0d actual %0d",
                                 $time, want.payload_byte, got.payload_byte);
                        n_errors++;
                    end
                    if (got.byte_index != want.byte_index) begin
                        $display("%0t: byte_index expected %0d actual %0d",
                                 $time, want.byte_index, got.byte_index);
                        n_errors++;
                    end
                    if (got.packet_length != want.packet_length) begin
                        $display("%0t: packet_length expected %0d actual %0d",
                                 $time, want.packet_length, got.packet_length);
                        n_errors++;
                    end
                    if (got.reply_char != want.reply_char) begin
                        $display("%0t: reply_char expected %0d actual %0d",
                                 $time, want.reply_char, got.reply_char);
                        n_errors++;
                    end
                end
            end
            // one long hold-off so the block fills up and raises full
            if (!held_once && n_results >= HOLD_AFTER) begin
                holdoff   = HOLD_CYCLES;
                held_once = 1'b1;
            end
            if (holdoff > 0) begin
                holdoff--;
                pop <= 1'b0;
            end else begin
                pop <= no_idle || ($urandom_range(99) >= 9);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? CH_0 + BYTE_W'(n) : CH_A + BYTE_W'(n) - HEX_A_VAL;
    endfunction

    task automatic add_ev(input t_rx_kind k, input logic [BYTE_W-1:0] b);
        t_rx_item it;
        it.kind = k;
        it.data = b;
        rx_events.push_back(it);
        if (k != RX_UNUSED)
            n_gen++;
    endtask

    // Framed packet; flaw picks an optional defect (values >= 25 give a clean packet)
    task automatic add_packet(input int len, input int flaw);
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] b;
        s = '0;
        add_ev(RX_BYTE, cfg_start);
        for (int i = 0; i < len; i++) begin
            do
                b = BYTE_W'($urandom);
            while ((b == cfg_start || b == cfg_end) && cfg_start != cfg_end);
            if (i == len / 2 && flaw < 5)
                add_ev(RX_BAD, '0);
            if (i == len / 2 && flaw >= 5 && flaw < 9) begin
                // restart mid-packet; sum starts over
                add_ev(RX_BYTE, cfg_start);
                s = '0;
            end
            add_ev(RX_BYTE, b);
            s = s + b;
        end
        add_ev(RX_BYTE, cfg_end);
        if (flaw >= 9 && flaw < 14)
            s = s ^ (8'h01 << $urandom_range(7));
        if (flaw >= 18 && flaw < 21) begin
            add_ev(RX_TIMEOUT, BYTE_W'($urandom));
            return;
        end
        if (flaw >= 14 && flaw < 18)
            add_ev(RX_BYTE, BYTE_W'($urandom));
        else if (flaw == 21)
            add_ev(RX_BAD, BYTE_W'($urandom));
        else
            add_ev(RX_BYTE, hex_char(s[7:4]));
        if (flaw >= 22 && flaw < 25)
            add_ev(RX_BAD, BYTE_W'($urandom));
        else
            add_ev(RX_BYTE, hex_char(s[3:0]));
    endtask

    // Mostly well-formed packets, the rest loose events of every kind
    task automatic add_random(input int target);
        int stop;
        int r;
        stop = n_gen + target;
        while (n_gen < stop) begin
            r = $urandom_range(99);
            if (r < 78) begin
                if ($urandom_range(99) < 3)
                    add_packet($urandom_range(80, 13), $urandom_range(99));
                else
                    add_packet($urandom_range(12), $urandom_range(99));
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    case ($urandom_range(5))
                        0:       add_ev(RX_BYTE, cfg_start);
                        1:       add_ev(RX_BYTE, cfg_end);
                        default: add_ev(t_rx_kind'($urandom_range(3)), BYTE_W'($urandom));
                    endcase
                end
            end
        end
    endtask

    // Wait until nothing is queued, offered or expected and the calm count reaches SETTLE
    task automatic drain();
        int calm;
        calm = 0;
        while (calm < SETTLE) begin
            @(posedge i_clk);
            if (rx_events.size() == 0 && !push && deframer_out_q.size() == 0)
                calm++;
            else
                calm = 0;
        end
    endtask

    task automatic set_regs(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                            input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] n);
        logic [BYTE_W-1:0] vals [4];
        logic [IDX_W-1:0]  idxs [4];
        vals = '{s, e, a, n};
        idxs = '{CFG_START, CFG_END, CFG_ACK, CFG_NAK};
        for (int i = 0; i < 4; i++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[i];
            i_cfg_data <= vals[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_start = s;
        cfg_end   = e;
        cfg_ack   = a;
        cfg_nak   = n;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: hunt-phase timeouts, ignored kind, good and bad packets
        add_ev(RX_TIMEOUT, 8'h00);           // first timeout in hunt: dropped
        add_ev(RX_UNUSED, 8'hFF);            // unused kind: ignored
        add_ev(RX_BYTE, 8'h78);              // marks seen_any
        add_ev(RX_TIMEOUT, 8'h00);           // now a reject with length 0
        add_ev(RX_BYTE, START_RST);          // good packet "a", sum 0x61
        add_ev(RX_BYTE, 8'h61);
        add_ev(RX_BYTE, END_RST);
        add_ev(RX_BYTE, hex_char(4'h6));
        add_ev(RX_BYTE, hex_char(4'h1));
        add_ev(RX_BYTE, START_RST);          // extremes, restart, bad mark
        add_ev(RX_BYTE, 8'hFF);
        add_ev(RX_BYTE, 8'h00);
        add_ev(RX_BYTE, START_RST);
        add_ev(RX_BYTE, 8'h01);
        add_ev(RX_BAD, 8'h00);
        add_ev(RX_BYTE, END_RST);
        add_ev(RX_BYTE, hex_char(4'h0));
        add_ev(RX_BYTE, hex_char(4'h1));
        add_ev(RX_BYTE, START_RST);          // non-hex digit, then bad mark digit
        add_ev(RX_BYTE, END_RST);
        add_ev(RX_BYTE, 8'h41);
        add_ev(RX_BAD, 8'h00);
        add_ev(RX_BYTE, START_RST);          // timeout after the end character
        add_ev(RX_BYTE, END_RST);
        add_ev(RX_TIMEOUT, 8'h00);
        add_ev(RX_BYTE, START_RST);          // empty good packet
        add_ev(RX_BYTE, END_RST);
        add_ev(RX_BYTE, hex_char(4'h0));
        add_ev(RX_BYTE, hex_char(4'h0));

        // Longest good packet, then one that overflows the buffer
        add_packet(BUFFER_BYTES - 1, 99);
        add_packet(BUFFER_BYTES, 99);
        add_random(50);
        drain();

        set_regs(8'h00, 8'hFF, 8'hFF, 8'h00);
        add_random(35);
        drain();

        // start and end characters the same
        set_regs(8'h7E, 8'h7E, 8'h01, 8'hFE);
        add_random(35);
        drain();

        set_regs(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                 BYTE_W'($urandom));
        add_random(35);
        drain();

        set_regs(8'hFF, 8'h00, 8'h80, 8'h7F);
        add_random(35);
        drain();

        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
